### hdl/sliding_window_median_filter_top_assert.svh
// Assertion macros shared by the median filter RTL.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Combinational or implication property, checked outside reset
`define SWMF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
// Next-cycle implication, checked outside reset
`define SWMF_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: assertion failed");
`else
`define SWMF_ASSERT(lbl, clk, rst_n, prop)
`define SWMF_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

### hdl/swmf_pkg.sv
// Package: widths, defaults and shared types of the median filter.
`timescale 1ns / 1ps
package swmf_pkg;

    // Sample and result width
    localparam int DATA_W = 16;
    // Fill count and rank width: holds any window size up to 15
    localparam int CNT_W = 4;

    localparam int WINDOW_SIZE_DEF = 5;
    localparam logic [DATA_W-1:0] INVALID_CODE_DEF = 16'hFFFF;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Control part of one queued job
    typedef struct packed {
        logic             is_invalid;
        logic [CNT_W-1:0] fill_count;
    } t_job_ctrl;

endpackage

### hdl/swmf_if.sv
// Stream interfaces for range samples in and median results out.
`timescale 1ns / 1ps
interface swmf_sample_if;
    logic                        valid;
    logic                        ready;
    logic [swmf_pkg::DATA_W-1:0] distance_sample;

    modport source (output valid, output distance_sample, input ready);
    modport sink   (input valid, input distance_sample, output ready);
endinterface

interface swmf_median_if;
    logic                        valid;
    logic                        ready;
    logic [swmf_pkg::DATA_W-1:0] median_distance;

    modport source (output valid, output median_distance, input ready);
    modport sink   (input valid, input median_distance, output ready);
endinterface

### hdl/swmf_front.sv
// Front end: accepts samples, flags invalid ones, keeps the ring window.
`timescale 1ns / 1ps
module swmf_front #(
    parameter int                          WINDOW_SIZE  = swmf_pkg::WINDOW_SIZE_DEF,
    parameter logic [swmf_pkg::DATA_W-1:0] INVALID_CODE = swmf_pkg::INVALID_CODE_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    swmf_sample_if.sink                             i_sample,
    input  logic                                    i_push_ready,
    output logic                                    o_push,
    output swmf_pkg::t_job_ctrl                     o_ctrl,
    output logic [WINDOW_SIZE*swmf_pkg::DATA_W-1:0] o_window
);
    import swmf_pkg::*;

    localparam int PTR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

    logic [DATA_W-1:0] r_window [WINDOW_SIZE];
    logic [DATA_W-1:0] n_window [WINDOW_SIZE];
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              accept;
    logic              is_invalid;

    assign i_sample.ready = i_push_ready;
    assign accept         = i_sample.valid && i_push_ready;
    assign is_invalid     = (i_sample.distance_sample == INVALID_CODE);

    // Ring write, pointer wrap and saturating fill count
    always_comb begin
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            if (PTR_W'(i) == r_ptr) begin
                n_window[i] = i_sample.distance_sample;
            end else begin
                n_window[i] = r_window[i];
            end
        end
        if (r_ptr == PTR_W'(WINDOW_SIZE - 1)) begin
            n_ptr = '0;
        end else begin
            n_ptr = r_ptr + 1'b1;
        end
        if (r_count < CNT_W'(WINDOW_SIZE)) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_count <= '0;
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                r_window[i] <= INVALID_CODE;
            end
        end else if (accept && !is_invalid) begin
            r_ptr   <= n_ptr;
            r_count <= n_count;
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                r_window[i] <= n_window[i];
            end
        end
    end

    // Job for the back end: window with this sample written in (an invalid sample is not kept)
    always_comb begin
        o_push            = accept;
        o_ctrl.is_invalid = is_invalid;
        o_ctrl.fill_count = n_count;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            o_window[i*DATA_W +: DATA_W] = n_window[i];
        end
    end

`include "sliding_window_median_filter_top_assert.svh"
    // compared at count width: a power-of-two window size does not fit the pointer
    `SWMF_ASSERT(a_ptr_range, i_clk, i_rst_n, CNT_W'(r_ptr) < CNT_W'(WINDOW_SIZE))
    `SWMF_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(WINDOW_SIZE))
    `SWMF_ASSERT(a_ptr_tracks_fill, i_clk, i_rst_n,
                 (r_count != CNT_W'(WINDOW_SIZE)) |-> (CNT_W'(r_ptr) == r_count))

endmodule

### hdl/swmf_queue.sv
// Short job queue between front and back ends.
`timescale 1ns / 1ps
module swmf_queue #(
    parameter int DEPTH = swmf_pkg::QUEUE_DEPTH_DEF,
    parameter int W     = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_not_full,
    input  logic         i_pop,
    output logic         o_not_empty,
    output logic [W-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_not_full  = (r_count != CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_data      = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`include "sliding_window_median_filter_top_assert.svh"
    `SWMF_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && !o_not_full))
    `SWMF_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && !o_not_empty))
    `SWMF_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, r_count != '0)

endmodule

### hdl/swmf_back.sv
// Back end: rank-based median selection in two register stages.
`timescale 1ns / 1ps
module swmf_back #(
    parameter int                          WINDOW_SIZE  = swmf_pkg::WINDOW_SIZE_DEF,
    parameter logic [swmf_pkg::DATA_W-1:0] INVALID_CODE = swmf_pkg::INVALID_CODE_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_job_valid,
    input  swmf_pkg::t_job_ctrl                     i_ctrl,
    input  logic [WINDOW_SIZE*swmf_pkg::DATA_W-1:0] i_window,
    output logic                                    o_pop,
    swmf_median_if.source                           o_median
);
    import swmf_pkg::*;

    logic [DATA_W-1:0]      win [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] n_before [WINDOW_SIZE];

    logic                   r_s1_valid;
    t_job_ctrl              r_s1_ctrl;
    logic [DATA_W-1:0]      r_s1_win [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] r_s1_before [WINDOW_SIZE];

    logic [CNT_W-1:0]       rank [WINDOW_SIZE];
    logic [CNT_W-1:0]       half;
    logic [DATA_W-1:0]      n_out_data;

    logic                   r_out_valid;
    logic [DATA_W-1:0]      r_out_data;
    logic                   adv_out;
    logic                   adv_s1;

    // Stall control: the output register frees, then stage one moves on
    assign adv_out = !r_out_valid || o_median.ready;
    assign adv_s1  = !r_s1_valid || adv_out;
    assign o_pop   = i_job_valid && adv_s1;

    // Stage one: pairwise order matrix over the filled entries.
    // Entry j sits before entry i if smaller, or equal with a lower index.
    always_comb begin
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            win[i] = i_window[i*DATA_W +: DATA_W];
        end
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            for (int j = 0; j < WINDOW_SIZE; j++) begin
                n_before[i][j] = (CNT_W'(j) < i_ctrl.fill_count) && (j != i) &&
                                 ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv_s1) begin
            r_s1_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_ctrl <= i_ctrl;
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                r_s1_win[i]    <= win[i];
                r_s1_before[i] <= n_before[i];
            end
        end
    end

    // Stage two: rank of each entry, pick the one at rank count/2; an invalid job gives the invalid code
    always_comb begin
        half       = r_s1_ctrl.fill_count >> 1;
        n_out_data = '0;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_SIZE; j++) begin
                rank[i] = rank[i] + CNT_W'(r_s1_before[i][j]);
            end
        end
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            if ((CNT_W'(i) < r_s1_ctrl.fill_count) && (rank[i] == half)) begin
                n_out_data = n_out_data | r_s1_win[i];
            end
        end
        if (r_s1_ctrl.is_invalid) begin
            n_out_data = INVALID_CODE;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_median.valid           = r_out_valid;
    assign o_median.median_distance = r_out_data;

endmodule

### hdl/sliding_window_median_filter_top.sv
// Path: a sample's job passes through the job queue, the stage-one register and the output register.
// Throughput: one sample per cycle; input ready falls only when the job queue is full.
// The order matrix is built in stage one and ranks are counted and selected in stage two.
// Reset (synchronous, active low): window to the invalid code, pointer and count to zero,
// queue and pipeline emptied.
`timescale 1ns / 1ps
module sliding_window_median_filter_top #(
    parameter int                          WINDOW_SIZE  = swmf_pkg::WINDOW_SIZE_DEF,
    parameter logic [swmf_pkg::DATA_W-1:0] INVALID_CODE = swmf_pkg::INVALID_CODE_DEF,
    parameter int                          QUEUE_DEPTH  = swmf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    swmf_sample_if.sink   i_sample,
    swmf_median_if.source o_median
);
    import swmf_pkg::*;

    localparam int WIN_W   = WINDOW_SIZE * DATA_W;
    localparam int ENTRY_W = $bits(t_job_ctrl) + WIN_W;

    logic               push;
    logic               push_ready;
    t_job_ctrl          push_ctrl;
    logic [WIN_W-1:0]   push_window;
    logic               pop;
    logic               job_valid;
    logic [ENTRY_W-1:0] head;
    t_job_ctrl          job_ctrl;
    logic [WIN_W-1:0]   job_window;

    swmf_front #(
        .WINDOW_SIZE  (WINDOW_SIZE),
        .INVALID_CODE (INVALID_CODE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (i_sample),
        .i_push_ready (push_ready),
        .o_push       (push),
        .o_ctrl       (push_ctrl),
        .o_window     (push_window)
    );

    swmf_queue #(
        .DEPTH (QUEUE_DEPTH),
        .W     (ENTRY_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      ({push_ctrl, push_window}),
        .o_not_full  (push_ready),
        .i_pop       (pop),
        .o_not_empty (job_valid),
        .o_data      (head)
    );

    assign job_ctrl   = head[ENTRY_W-1 -: $bits(t_job_ctrl)];
    assign job_window = head[WIN_W-1:0];

    swmf_back #(
        .WINDOW_SIZE  (WINDOW_SIZE),
        .INVALID_CODE (INVALID_CODE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_ctrl      (job_ctrl),
        .i_window    (job_window),
        .o_pop       (pop),
        .o_median    (o_median)
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the median filter: directed and random samples under handshake stalls.
module tb_top;
    import swmf_pkg::*;

    localparam int                WIN          = WINDOW_SIZE_DEF;
    localparam logic [DATA_W-1:0] INV          = INVALID_CODE_DEF;
    localparam int                RANDOM_ITEMS = 500;
    localparam int                MAX_REPORTS  = 10;

    // Directed samples: missing reading on an empty window, missing readings part-way
    // through the fill, an even count (upper median), extremes, alternating bit patterns,
    // duplicates, overwriting of the oldest entry and missing readings on a full window.
    localparam logic [DATA_W-1:0] DIRECTED [23] = '{
        16'hFFFF, 16'd1000, 16'hFFFF, 16'h0000, 16'hFFFE, 16'h5555, 16'hAAAA,
        16'h0000, 16'h0000, 16'h0000, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFF,
        16'h0001, 16'h8000, 16'h7FFF, 16'h0001, 16'h0001, 16'hFFFF, 16'hFFFE,
        16'h0000, 16'hFFFE
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    swmf_sample_if sample_if ();
    swmf_median_if median_if ();

    // Bench-side drivers, known from time zero
    logic              smp_valid = 1'b0;
    logic [DATA_W-1:0] smp_data  = '0;
    logic              med_ready = 1'b0;

    assign sample_if.valid           = smp_valid;
    assign sample_if.distance_sample = smp_data;
    assign median_if.ready           = med_ready;

    sliding_window_median_filter_top dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_sample (sample_if),
        .o_median (median_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Samples waiting to be sent, medians waiting to be seen
    logic [DATA_W-1:0] sample_queue [$];
    logic [DATA_W-1:0] median_expected [$];

    int samples_accepted = 0;
    int sample_total     = 0;
    int mismatch_count   = 0;
    int send_idle_pct;
    int recv_idle_pct;

    // Predictor state: ring window, write pointer, fill count
    logic [DATA_W-1:0] win_store [WIN];
    int                win_ptr  = 0;
    int                win_fill = 0;

    logic [DATA_W-1:0] want_median;

    // Window update and median of the filled entries; missing readings leave state alone
    function automatic logic [DATA_W-1:0] next_median(input logic [DATA_W-1:0] sample);
        logic [DATA_W-1:0] sorted [WIN];
        logic [DATA_W-1:0] key;
        int                n;
        int                j;
        if (sample == INV) begin
            return INV;
        end
        win_store[win_ptr] = sample;
        win_ptr = (win_ptr + 1) % WIN;
        if (win_fill < WIN) begin
            win_fill++;
        end
        n = win_fill;
        for (int i = 0; i < n; i++) begin
            sorted[i] = win_store[i];
        end
        // insertion sort, ascending
        for (int i = 1; i < n; i++) begin
            key = sorted[i];
            j   = i;
            while (j > 0 && sorted[j-1] > key) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        return sorted[n / 2];
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s: median_distance expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Stall profile: sender light / receiver heavy, then swapped, then none
    always_comb begin
        if (samples_accepted < sample_total / 3) begin
            send_idle_pct = 18;
            recv_idle_pct = 74;
        end else if (samples_accepted < 2 * sample_total / 3) begin
            send_idle_pct = 74;
            recv_idle_pct = 18;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // Sample driver: predicts on each accepted transaction, then loads the next sample
    always @(posedge clk) begin
        if (!rst_n) begin
            smp_valid <= 1'b0;
        end else begin
            if (smp_valid && sample_if.ready) begin
                median_expected.push_back(next_median(smp_data));
                samples_accepted++;
            end
            if (!smp_valid || sample_if.ready) begin
                if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    smp_valid <= 1'b1;
                    smp_data  <= sample_queue.pop_front();
                end else begin
                    smp_valid <= 1'b0;
                end
            end
        end
    end

    // Median monitor: checks each result transaction against the oldest prediction
    always @(posedge clk) begin
        if (!rst_n) begin
            med_ready <= 1'b0;
        end else begin
            if (median_if.valid && med_ready) begin
                if (median_expected.size() == 0) begin
                    report_mismatch("unexpected result", INV, median_if.median_distance);
                end else begin
                    want_median = median_expected.pop_front();
                    if (median_if.median_distance !== want_median) begin
                        report_mismatch("mismatch", want_median, median_if.median_distance);
                    end
                end
            end
            med_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int r;
        foreach (win_store[i]) begin
            win_store[i] = INV;
        end
        foreach (DIRECTED[i]) begin
            sample_queue.push_back(DIRECTED[i]);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                sample_queue.push_back(INV);
            end else if (r < 30) begin
                // tight cluster: plenty of ties in the window
                sample_queue.push_back(DATA_W'($urandom_range(7)));
            end else if (r < 40) begin
                case ($urandom_range(4))
                    0:       sample_queue.push_back(16'h0000);
                    1:       sample_queue.push_back(16'h0001);
                    2:       sample_queue.push_back(16'h7FFF);
                    3:       sample_queue.push_back(16'h8000);
                    default: sample_queue.push_back(16'hFFFE);
                endcase
            end else begin
                sample_queue.push_back(DATA_W'($urandom()));
            end
        end
        sample_total = sample_queue.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (samples_accepted < sample_total || median_expected.size() != 0) begin
            @(posedge clk);
        end
        // catch any stray result after the last one
        repeat (10) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/swmf_pkg.sv
hdl/swmf_if.sv
hdl/swmf_front.sv
hdl/swmf_queue.sv
hdl/swmf_back.sv
hdl/sliding_window_median_filter_top.sv
sim/tb_top.sv
